FILE: design/asu_pkg.sv
// shared types, constants and codes of the arm subset execute unit
// no dependencies; imported by every module of the block

package asu_pkg;

	// sizes of the architectural state
	localparam int unsigned NUM_REGS    = 12;
	localparam int unsigned MEM_WORDS   = 8;
	localparam int unsigned PROG_DEPTH  = 1024;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int unsigned MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned IDX_W  = 10;
	localparam int unsigned RIDX_W = 4;

	// configuration port
	localparam int unsigned CFG_AW = 3;
	localparam logic [31:0] MEM_BASE_RESET = 32'h0000_0100;
	localparam logic        CFG_IDX_MEM_BASE = 1'b0;

	// command codes
	localparam logic [4:0] CMD_MOV  = 5'd0;
	localparam logic [4:0] CMD_MVN  = 5'd1;
	localparam logic [4:0] CMD_ADD  = 5'd2;
	localparam logic [4:0] CMD_SUB  = 5'd3;
	localparam logic [4:0] CMD_AND  = 5'd4;
	localparam logic [4:0] CMD_ORR  = 5'd5;
	localparam logic [4:0] CMD_XOR  = 5'd6;
	localparam logic [4:0] CMD_LSL  = 5'd7;
	localparam logic [4:0] CMD_LSR  = 5'd8;
	localparam logic [4:0] CMD_ADDS = 5'd9;
	localparam logic [4:0] CMD_SUBS = 5'd10;
	localparam logic [4:0] CMD_ANDS = 5'd11;
	localparam logic [4:0] CMD_ORRS = 5'd12;
	localparam logic [4:0] CMD_XORS = 5'd13;
	localparam logic [4:0] CMD_CMP  = 5'd14;
	localparam logic [4:0] CMD_LDR  = 5'd15;
	localparam logic [4:0] CMD_STR  = 5'd16;
	localparam logic [4:0] CMD_B    = 5'd17;

	// condition codes
	localparam logic [2:0] COND_AL = 3'd0;
	localparam logic [2:0] COND_EQ = 3'd1;
	localparam logic [2:0] COND_NE = 3'd2;
	localparam logic [2:0] COND_GT = 3'd3;
	localparam logic [2:0] COND_LT = 3'd4;
	localparam logic [2:0] COND_GE = 3'd5;
	localparam logic [2:0] COND_LE = 3'd6;

	// second operand kinds as coded in the item
	localparam logic [1:0] MK_ZERO = 2'd0;
	localparam logic [1:0] MK_REG  = 2'd1;
	localparam logic [1:0] MK_IMM  = 2'd2;

	// flag bit positions
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	// execute operation classes
	typedef enum logic [3:0] {
		OP_MOV, OP_MVN, OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_XOR,
		OP_LSL, OP_LSR, OP_LDR, OP_STR, OP_B, OP_NOP
	} op_t;

	// flag update modes
	typedef enum logic [1:0] {
		FL_NONE, FL_NZ, FL_ALL
	} fl_t;

	// second operand source
	typedef enum logic [1:0] {
		M_ZERO, M_REG, M_IMM
	} msel_t;

	// input item
	typedef struct packed {
		logic [4:0]          command;
		logic [2:0]          cond;
		logic [RIDX_W-1:0]   dest_reg;
		logic                n_is_imm;
		logic [RIDX_W-1:0]   n_reg;
		logic signed [31:0]  n_imm;
		logic [1:0]          m_kind;
		logic [RIDX_W-1:0]   m_reg;
		logic signed [31:0]  m_imm;
		logic [IDX_W-1:0]    branch_target;
		logic [IDX_W-1:0]    current_index;
	} instr_t;

	// result item
	typedef struct packed {
		logic [IDX_W-1:0]    next_index;
		logic                branch_taken;
		logic                cond_passed;
		logic                reg_write;
		logic [RIDX_W-1:0]   reg_index;
		logic [31:0]         reg_value;
		logic [3:0]          flags;
		logic                mem_error;
	} res_t;

	// classified item between front and back
	typedef struct packed {
		op_t                 op;
		fl_t                 fl;
		logic                wr;
		logic [2:0]          cond;
		logic [RIDX_W-1:0]   dest;
		logic                dest_ok;
		logic                n_is_imm;
		logic [31:0]         n_imm;
		logic [RIDX_W-1:0]   ra;
		logic [RIDX_W-1:0]   rb;
		msel_t               msel;
		logic [31:0]         m_imm;
		logic [IDX_W-1:0]    seq_next;
		logic [IDX_W-1:0]    tgt_next;
	} dec_t;

endpackage

FILE: design/asu_front.sv
// front end: accepts items and classifies them into operation classes
// depends on asu_pkg; feeds asu_queue

module asu_front import asu_pkg::*; (
	input  logic   push,
	output logic   full,
	input  instr_t instr,
	input  logic   q_full,
	output logic   q_push,
	output dec_t   q_data
);

	logic [IDX_W:0] seq_sum;
	logic [31:0]    seq_mod;
	logic [31:0]    tgt_mod;

	// accept handshake follows the queue
	assign full   = q_full;
	assign q_push = push & ~q_full;

	// next index candidates, wrapped to program depth
	assign seq_sum = {1'b0, instr.current_index} + {{IDX_W{1'b0}}, 1'b1};
	assign seq_mod = 32'(seq_sum) % PROG_DEPTH;
	assign tgt_mod = 32'(instr.branch_target) % PROG_DEPTH;

	// command classification
	always_comb begin
		q_data          = '0;
		q_data.op       = OP_NOP;
		q_data.fl       = FL_NONE;
		q_data.wr       = 1'b0;
		unique case (instr.command)
			CMD_MOV:  begin q_data.op = OP_MOV; q_data.wr = 1'b1; end
			CMD_MVN:  begin q_data.op = OP_MVN; q_data.wr = 1'b1; end
			CMD_ADD:  begin q_data.op = OP_ADD; q_data.wr = 1'b1; end
			CMD_SUB:  begin q_data.op = OP_SUB; q_data.wr = 1'b1; end
			CMD_AND:  begin q_data.op = OP_AND; q_data.wr = 1'b1; end
			CMD_ORR:  begin q_data.op = OP_ORR; q_data.wr = 1'b1; end
			CMD_XOR:  begin q_data.op = OP_XOR; q_data.wr = 1'b1; end
			CMD_LSL:  begin q_data.op = OP_LSL; q_data.wr = 1'b1; end
			CMD_LSR:  begin q_data.op = OP_LSR; q_data.wr = 1'b1; end
			CMD_ADDS: begin q_data.op = OP_ADD; q_data.wr = 1'b1; q_data.fl = FL_ALL; end
			CMD_SUBS: begin q_data.op = OP_SUB; q_data.wr = 1'b1; q_data.fl = FL_ALL; end
			CMD_ANDS: begin q_data.op = OP_AND; q_data.wr = 1'b1; q_data.fl = FL_NZ; end
			CMD_ORRS: begin q_data.op = OP_ORR; q_data.wr = 1'b1; q_data.fl = FL_NZ; end
			CMD_XORS: begin q_data.op = OP_XOR; q_data.wr = 1'b1; q_data.fl = FL_NZ; end
			CMD_CMP:  begin q_data.op = OP_SUB; q_data.fl = FL_ALL; end
			CMD_LDR:  begin q_data.op = OP_LDR; q_data.wr = 1'b1; end
			CMD_STR:  begin q_data.op = OP_STR; end
			CMD_B:    begin q_data.op = OP_B; end
			default:  begin q_data.op = OP_NOP; end
		endcase

		// operand selection
		unique case (instr.m_kind)
			MK_REG:  q_data.msel = M_REG;
			MK_IMM:  q_data.msel = M_IMM;
			default: q_data.msel = M_ZERO;
		endcase

		q_data.cond     = instr.cond;
		q_data.dest     = instr.dest_reg;
		q_data.dest_ok  = (32'(instr.dest_reg) < NUM_REGS);
		q_data.n_is_imm = instr.n_is_imm;
		q_data.n_imm    = instr.n_imm;
		q_data.ra       = instr.n_reg;
		// a store reads its data through the second port
		q_data.rb       = (instr.command == CMD_STR) ? instr.dest_reg : instr.m_reg;
		q_data.m_imm    = instr.m_imm;
		q_data.seq_next = seq_mod[IDX_W-1:0];
		q_data.tgt_next = tgt_mod[IDX_W-1:0];
	end

endmodule

FILE: design/asu_queue.sv
// short queue of classified items between front and back
// depends on asu_pkg

module asu_queue import asu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  dec_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output logic rd_valid,
	output dec_t rd_data
);

	dec_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign q_full   = (32'(count_q) == QUEUE_DEPTH);
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en & ~q_full;
	assign do_rd    = rd_en & rd_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: design/asu_back.sv
// back end: register file, flags, data memory, execute stage and result register
// depends on asu_pkg; takes classified items from asu_queue

module asu_back import asu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] mem_base,
	input  logic        q_valid,
	input  dec_t        q_head,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output res_t        result
);

	// register file: two read ports with registered data
	logic [31:0]   rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;

	logic [31:0]   dmem_q [MEM_WORDS];
	logic [3:0]    nzcv_q;

	dec_t          dec_s1;
	logic          valid_s1;
	res_t          result_q;
	logic          out_valid_q;

	logic          fire;
	logic          load;
	logic          ra_ok, rb_ok;
	logic          wr_hit_a, wr_hit_b;

	logic [31:0]   a, b, r;
	logic [32:0]   add_w, sub_w;
	logic [31:0]   mem_idx;
	logic          in_range;
	logic          big_shift;
	logic          pass, c_new, v_new;
	logic          wr_req, do_write, do_store, merr, taken;
	logic [3:0]    flags_new;
	res_t          res_d;

	// stage control
	assign fire  = valid_s1 & (~out_valid_q | pop);
	assign load  = q_valid & (~valid_s1 | fire);
	assign q_pop = load;

	// operand fetch with bypass of the write in flight
	assign ra_ok    = (32'(q_head.ra) < NUM_REGS);
	assign rb_ok    = (32'(q_head.rb) < NUM_REGS);
	assign wr_hit_a = fire & do_write & (dec_s1.dest == q_head.ra);
	assign wr_hit_b = fire & do_write & (dec_s1.dest == q_head.rb);

	always_ff @(posedge clk) begin
		if (load) begin
			if (wr_hit_a) begin
				rd_a_q <= r;
			end else if (ra_ok && rf_vld_q[q_head.ra[REG_AW-1:0]]) begin
				rd_a_q <= rf_mem[q_head.ra[REG_AW-1:0]];
			end else begin
				rd_a_q <= '0;
			end
			if (wr_hit_b) begin
				rd_b_q <= r;
			end else if (rb_ok && rf_vld_q[q_head.rb[REG_AW-1:0]]) begin
				rd_b_q <= rf_mem[q_head.rb[REG_AW-1:0]];
			end else begin
				rd_b_q <= '0;
			end
		end
		if (fire && do_write) begin
			rf_mem[dec_s1.dest[REG_AW-1:0]] <= r;
		end
	end

	// register valid bits stand in for the cleared file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (fire && do_write) begin
			rf_vld_q[dec_s1.dest[REG_AW-1:0]] <= 1'b1;
		end
	end

	// execute stage item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_s1 <= q_head;
		end
	end

	// operands and shared arithmetic
	always_comb begin
		a = dec_s1.n_is_imm ? dec_s1.n_imm : rd_a_q;
		unique case (dec_s1.msel)
			M_REG:   b = rd_b_q;
			M_IMM:   b = dec_s1.m_imm;
			M_ZERO:  b = '0;
			default: b = '0;
		endcase
	end

	assign add_w     = {1'b0, a} + {1'b0, b};
	assign sub_w     = {1'b0, a} - {1'b0, b};
	assign mem_idx   = a - mem_base;
	assign in_range  = (mem_idx < 32'(MEM_WORDS));
	assign big_shift = |b[31:5];

	// condition test against current flags
	always_comb begin
		unique case (dec_s1.cond)
			COND_EQ: pass = nzcv_q[FLAG_Z];
			COND_NE: pass = ~nzcv_q[FLAG_Z];
			COND_GT: pass = ~nzcv_q[FLAG_Z] & (nzcv_q[FLAG_N] == nzcv_q[FLAG_V]);
			COND_LT: pass = (nzcv_q[FLAG_N] != nzcv_q[FLAG_V]);
			COND_GE: pass = (nzcv_q[FLAG_N] == nzcv_q[FLAG_V]);
			COND_LE: pass = nzcv_q[FLAG_Z] | (nzcv_q[FLAG_N] != nzcv_q[FLAG_V]);
			default: pass = 1'b1;
		endcase
	end

	// operation
	always_comb begin
		r        = '0;
		c_new    = 1'b0;
		v_new    = 1'b0;
		wr_req   = 1'b0;
		do_store = 1'b0;
		merr     = 1'b0;
		taken    = 1'b0;
		if (pass) begin
			unique case (dec_s1.op)
				OP_MOV: begin r = a; wr_req = dec_s1.wr; end
				OP_MVN: begin r = ~a; wr_req = dec_s1.wr; end
				OP_ADD: begin
					r      = add_w[31:0];
					c_new  = add_w[32];
					v_new  = (~(a ^ b) & (a ^ add_w[31:0])) >> 31 != '0;
					wr_req = dec_s1.wr;
				end
				OP_SUB: begin
					r      = sub_w[31:0];
					c_new  = ~sub_w[32];
					v_new  = ((a ^ b) & (a ^ sub_w[31:0])) >> 31 != '0;
					wr_req = dec_s1.wr;
				end
				OP_AND: begin r = a & b; wr_req = dec_s1.wr; end
				OP_ORR: begin r = a | b; wr_req = dec_s1.wr; end
				OP_XOR: begin r = a ^ b; wr_req = dec_s1.wr; end
				OP_LSL: begin r = big_shift ? '0 : (a << b[4:0]); wr_req = dec_s1.wr; end
				OP_LSR: begin r = big_shift ? '0 : (a >> b[4:0]); wr_req = dec_s1.wr; end
				OP_LDR: begin
					if (in_range) begin
						r      = dmem_q[mem_idx[MEM_AW-1:0]];
						wr_req = 1'b1;
					end else begin
						merr = 1'b1;
					end
				end
				OP_STR: begin
					do_store = in_range;
					merr     = ~in_range;
				end
				OP_B:    taken = 1'b1;
				OP_NOP:  r = '0;
				default: r = '0;
			endcase
		end
		do_write = wr_req & dec_s1.dest_ok;
	end

	// flag update
	always_comb begin
		flags_new = nzcv_q;
		if (pass) begin
			unique case (dec_s1.fl)
				FL_ALL:  flags_new = {r[31], (r == '0), c_new, v_new};
				FL_NZ:   flags_new = {r[31], (r == '0), nzcv_q[FLAG_C], nzcv_q[FLAG_V]};
				FL_NONE: flags_new = nzcv_q;
				default: flags_new = nzcv_q;
			endcase
		end
	end

	// result fields
	always_comb begin
		res_d              = '0;
		res_d.next_index   = taken ? dec_s1.tgt_next : dec_s1.seq_next;
		res_d.branch_taken = taken;
		res_d.cond_passed  = pass;
		res_d.reg_write    = do_write;
		res_d.reg_index    = do_write ? dec_s1.dest : '0;
		res_d.reg_value    = do_write ? r : '0;
		res_d.flags        = flags_new;
		res_d.mem_error    = merr;
	end

	// flags and data memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nzcv_q <= '0;
			for (int i = 0; i < int'(MEM_WORDS); i++) begin
				dmem_q[i] <= '0;
			end
		end else if (fire) begin
			nzcv_q <= flags_new;
			if (do_store) begin
				dmem_q[mem_idx[MEM_AW-1:0]] <= rd_b_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res_d;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = result_q;

`ifndef SYNTH
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(result_q))
		else $error("result changed while stalled");
	a_write_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !result_q.reg_write || result_q.cond_passed)
		else $error("register write without passed condition");
	a_branch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.branch_taken |-> result_q.cond_passed && !result_q.reg_write)
		else $error("taken branch with register write or failed condition");
	a_flags_kept: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !pass |=> nzcv_q == $past(nzcv_q))
		else $error("flags changed by failed condition");
	a_merr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.mem_error |-> !result_q.reg_write)
		else $error("memory error with register write");
`endif

endmodule

FILE: design/arm_subset_execute_unit.sv
// Executes decoded ARM-style instructions, one item per instruction.
// Input channel: push/full with an instr item; an item is taken when push
// is high and full is low. Result channel: empty/pop with a result item;
// the oldest result sits on result while empty is low and leaves on pop.
// Configuration: APB-style port, mem_base at byte address 0, pready tied high.
// Order: a taken item goes through queue, execute stage and result register.
// Throughput: one item per cycle while pop keeps up; operands are read from
// the register file into registers as an item enters the execute stage, which
// bypasses the item in front's write; dependent instructions go back to back.
// Reset: register file, NZCV and data memory read as zero (valid bits on the
// register file, no clearing pass); mem_base returns to 0x100.
// Stall: if pop stays low the result register holds, the execute stage
// stops, the four-entry queue fills and full rises.
// depends on asu_pkg, asu_front, asu_queue, asu_back

module arm_subset_execute_unit import asu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  instr_t            instr,
	output logic              empty,
	input  logic              pop,
	output res_t              result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic        q_full;
	logic        q_push;
	dec_t        q_wr_data;
	logic        q_pop;
	logic        q_valid;
	dec_t        q_head;
	logic [31:0] mem_base_q;
	logic        cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= MEM_BASE_RESET;
		end else if (cfg_wr && paddr[CFG_AW-1:2] == CFG_IDX_MEM_BASE) begin
			mem_base_q <= pwdata;
		end
	end

	assign prdata = (paddr[CFG_AW-1:2] == CFG_IDX_MEM_BASE) ? mem_base_q : '0;

	// front, queue and back
	asu_front u_front (
		.push   (push),
		.full   (full),
		.instr  (instr),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr_data)
	);

	asu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_wr_data),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_head)
	);

	asu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_base (mem_base_q),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
